// File: sv/rgba_over_blend_with_opacity_macros.svh
// ----------------------------------------------------------------------------
// RGBA over blend assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RGBA_OVER_BLEND_WITH_OPACITY_MACROS_SVH
`define RGBA_OVER_BLEND_WITH_OPACITY_MACROS_SVH

// same-cycle implication
`define RGBOB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rgbob assertion failed (same cycle)");

// next-cycle implication
`define RGBOB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rgbob assertion failed (next cycle)");

`endif

// File: sv/rgbob_pkg.sv
// ----------------------------------------------------------------------------
// RGBA over blend package
// Widths and sideband types shared by the blend pipeline and its divider.
// ----------------------------------------------------------------------------
package rgbob_pkg;

  localparam int QW     = 9;   // quotient bits, one more than a channel
  localparam int RW     = 27;  // dividend / remainder width
  localparam int DW     = 18;  // divisor width
  localparam int LANES  = 3;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pix_t;

  // bypass: the blend result is replaced by pix; otherwise pix.alpha
  // carries the blended alpha
  typedef struct packed {
    logic bypass;
    pix_t pix;
  } side_t;

endpackage

// File: sv/rgba_over_blend_with_opacity.sv
// ----------------------------------------------------------------------------
// RGBA over blend with opacity
// Straight-alpha Porter-Duff over of a layer pixel onto a destination pixel.
// ----------------------------------------------------------------------------
// Takes one pixel pair per cycle and returns one blended pixel per cycle
// while out_ready does not stall the output: four stages scale the layer
// alpha by the opacity register, form the products and the blended alpha,
// then a nine-stage restoring divider (one quotient bit per stage, three
// lanes) produces the three colors while the alpha rides along beside it.
// The whole pipeline holds while a result waits on out_ready. Write
// layer_opacity only while no pixel is in flight; pixels take the value
// present when they enter.
module rgba_over_blend_with_opacity (
  input  logic       clk,
  input  logic       rst,
  input  logic       layer_opacity_valid,
  output logic       layer_opacity_ready,
  input  logic [7:0] layer_opacity,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] dst_red,
  input  logic [7:0] dst_green,
  input  logic [7:0] dst_blue,
  input  logic [7:0] dst_alpha,
  input  logic [7:0] src_red,
  input  logic [7:0] src_green,
  input  logic [7:0] src_blue,
  input  logic [7:0] src_alpha,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha
);

  logic [7:0] opacity;
  logic       en;

  assign layer_opacity_ready = 1'b1;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      opacity <= 8'd255;
    end else if (layer_opacity_valid) begin
      opacity <= layer_opacity;
    end
  end

  // stage 1: capture pixels, alpha times opacity
  logic             v1;
  rgbob_pkg::pix_t  d1, s1;
  logic [15:0]      p1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1 <= '{dst_red, dst_green, dst_blue, dst_alpha};
      s1 <= '{src_red, src_green, src_blue, src_alpha};
      p1 <= src_alpha * opacity;
    end
  end

  // stage 2: sa = floor(p / 255), estimate p >> 8 is at most one low
  logic             v2;
  rgbob_pkg::pix_t  d2, s2;
  logic [7:0]       sa2;
  logic [7:0]       sa_est;
  logic [15:0]      sa_rem;
  logic [7:0]       sa_next;

  assign sa_est  = p1[15:8];
  assign sa_rem  = p1 - 16'(sa_est * 9'd255);
  assign sa_next = (sa_rem >= 16'd255) ? sa_est + 8'd1 : sa_est;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2  <= d1;
      s2  <= s1;
      sa2 <= sa_next;
    end
  end

  // stage 3: weighted products
  logic                  v3;
  rgbob_pkg::side_t      side3;
  logic [7:0]            sa3, inv3;
  logic [2:0][15:0]      ps3, pd3;
  logic [15:0]           dinv3;
  rgbob_pkg::side_t      side_next;
  logic [7:0]            inv_next;

  assign inv_next = 8'd255 - sa2;

  always_comb begin
    side_next.bypass = (sa2 == 8'd0) || (sa2 == 8'd255);
    if (sa2 == 8'd0) begin
      side_next.pix = d2;
    end else begin
      side_next.pix = '{s2.red, s2.green, s2.blue, 8'd255};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side3  <= side_next;
      sa3    <= sa2;
      inv3   <= inv_next;
      ps3[0] <= s2.red   * sa2;
      ps3[1] <= s2.green * sa2;
      ps3[2] <= s2.blue  * sa2;
      pd3[0] <= d2.red   * d2.alpha;
      pd3[1] <= d2.green * d2.alpha;
      pd3[2] <= d2.blue  * d2.alpha;
      dinv3  <= d2.alpha * inv_next;
    end
  end

  // stage 4: numerators and N, rounded dividends, blended alpha
  logic                                                 v4;
  rgbob_pkg::side_t                                     side4;
  logic [rgbob_pkg::LANES-1:0][rgbob_pkg::RW-1:0]       dvd4;
  logic [rgbob_pkg::LANES-1:0][rgbob_pkg::DW-1:0]       dvs4;
  logic [16:0]                                          n_sum;
  logic [rgbob_pkg::LANES-1:0][rgbob_pkg::RW-1:0]       dvd_next;
  logic [rgbob_pkg::LANES-1:0][rgbob_pkg::DW-1:0]       dvs_next;
  logic [15:0]                                          a_t;
  logic [7:0]                                           a_est;
  logic [15:0]                                          a_rem;
  logic [7:0]                                           a_next;
  rgbob_pkg::side_t                                     side4_next;

  assign n_sum = 17'(sa3 * 9'd255) + 17'(dinv3);

  // floor((2N + 255) / 510) equals floor((N + 127) / 255)
  assign a_t    = 16'(n_sum) + 16'd127;
  assign a_est  = a_t[15:8];
  assign a_rem  = a_t - 16'(a_est * 9'd255);
  assign a_next = (a_rem >= 16'd255) ? a_est + 8'd1 : a_est;

  always_comb begin
    side4_next = side3;
    if (!side3.bypass) begin
      side4_next.pix.alpha = a_next;
    end
  end

  always_comb begin
    logic [24:0] num;
    for (int c = 0; c < rgbob_pkg::LANES; c++) begin
      num         = 25'(ps3[c] * 9'd255) + 25'(pd3[c] * inv3);
      dvd_next[c] = {num, 1'b0} + rgbob_pkg::RW'(n_sum);
      dvs_next[c] = {n_sum, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side4 <= side4_next;
      dvd4  <= dvd_next;
      dvs4  <= dvs_next;
    end
  end

  logic [rgbob_pkg::LANES-1:0][rgbob_pkg::QW-1:0] quo;
  rgbob_pkg::side_t                              side_o;
  logic [rgbob_pkg::LANES-1:0][7:0]              sat;

  rgbob_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .dividend  (dvd4),
    .divisor   (dvs4),
    .side_in   (side4),
    .out_valid (out_valid),
    .quotient  (quo),
    .side_out  (side_o)
  );

  always_comb begin
    for (int l = 0; l < rgbob_pkg::LANES; l++) begin
      sat[l] = quo[l][rgbob_pkg::QW-1] ? 8'd255 : quo[l][7:0];
    end
  end

  assign out_red   = side_o.bypass ? side_o.pix.red   : sat[0];
  assign out_green = side_o.bypass ? side_o.pix.green : sat[1];
  assign out_blue  = side_o.bypass ? side_o.pix.blue  : sat[2];
  assign out_alpha = side_o.pix.alpha;

endmodule

// File: sv/rgbob_div.sv
// ----------------------------------------------------------------------------
// RGBA over blend divider
// Three-lane restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module rgbob_div (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         en,
  input  logic                                         in_valid,
  input  logic [rgbob_pkg::LANES-1:0][rgbob_pkg::RW-1:0] dividend,
  input  logic [rgbob_pkg::LANES-1:0][rgbob_pkg::DW-1:0] divisor,
  input  rgbob_pkg::side_t                             side_in,
  output logic                                         out_valid,
  output logic [rgbob_pkg::LANES-1:0][rgbob_pkg::QW-1:0] quotient,
  output rgbob_pkg::side_t                             side_out
);

  localparam int NS = rgbob_pkg::QW;
  localparam int L  = rgbob_pkg::LANES;

  logic [NS-1:0]                                   v;
  logic [L-1:0][rgbob_pkg::RW-1:0]                 rem   [NS];
  logic [L-1:0][rgbob_pkg::DW-1:0]                 dvs   [NS];
  logic [L-1:0][rgbob_pkg::QW-1:0]                 q     [NS];
  rgbob_pkg::side_t                                sd    [NS];

  logic [NS-1:0]                                   v_in;
  logic [L-1:0][rgbob_pkg::RW-1:0]                 rem_in  [NS];
  logic [L-1:0][rgbob_pkg::DW-1:0]                 dvs_in  [NS];
  logic [L-1:0][rgbob_pkg::QW-1:0]                 q_in    [NS];
  rgbob_pkg::side_t                                sd_in   [NS];
  logic [L-1:0][rgbob_pkg::RW-1:0]                 rem_next[NS];
  logic [L-1:0][rgbob_pkg::QW-1:0]                 q_next  [NS];

  genvar k;
  generate
    for (k = 0; k < NS; k++) begin : g_stage
      if (k == 0) begin : g_first
        assign v_in[k]   = in_valid;
        assign rem_in[k] = dividend;
        assign dvs_in[k] = divisor;
        assign q_in[k]   = '0;
        assign sd_in[k]  = side_in;
      end else begin : g_rest
        assign v_in[k]   = v[k-1];
        assign rem_in[k] = rem[k-1];
        assign dvs_in[k] = dvs[k-1];
        assign q_in[k]   = q[k-1];
        assign sd_in[k]  = sd[k-1];
      end

      // try subtracting the divisor scaled to this quotient bit
      always_comb begin
        logic [rgbob_pkg::RW-1:0] sh;
        rem_next[k] = rem_in[k];
        q_next[k]   = q_in[k];
        for (int l = 0; l < L; l++) begin
          sh = rgbob_pkg::RW'(dvs_in[k][l]) << (NS - 1 - k);
          if (rem_in[k][l] >= sh) begin
            rem_next[k][l]          = rem_in[k][l] - sh;
            q_next[k][l][NS - 1 - k] = 1'b1;
          end
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          v[k] <= 1'b0;
        end else if (en) begin
          v[k] <= v_in[k];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem[k] <= rem_next[k];
          dvs[k] <= dvs_in[k];
          q[k]   <= q_next[k];
          sd[k]  <= sd_in[k];
        end
      end
    end
  endgenerate

  assign out_valid = v[NS-1];
  assign quotient  = q[NS-1];
  assign side_out  = sd[NS-1];

endmodule

// File: sv/rgbob_check.sv
// ----------------------------------------------------------------------------
// RGBA over blend checker
// Port-level assertions on the blend block, bound to the top level.
// ----------------------------------------------------------------------------
`include "rgba_over_blend_with_opacity_macros.svh"

module rgbob_check (
  input logic       clk,
  input logic       rst,
  input logic       layer_opacity_valid,
  input logic       layer_opacity_ready,
  input logic [7:0] layer_opacity,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] dst_red,
  input logic [7:0] dst_green,
  input logic [7:0] dst_blue,
  input logic [7:0] dst_alpha,
  input logic [7:0] src_red,
  input logic [7:0] src_green,
  input logic [7:0] src_blue,
  input logic [7:0] src_alpha,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic [7:0] out_alpha
);

  // a stalled result holds
  `RGBOB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({out_red, out_green, out_blue, out_alpha}))
  // nothing waiting at the output means the pipe can take a transfer
  `RGBOB_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)
  // a result leaving frees the pipe for a new pixel in the same cycle
  `RGBOB_ASSERT_NOW(a_ready_on_drain, out_valid && out_ready, in_ready)
  // opacity register always takes a write
  `RGBOB_ASSERT_NOW(a_cfg_ready, layer_opacity_valid, layer_opacity_ready)

endmodule

bind rgba_over_blend_with_opacity rgbob_check u_rgbob_check (.*);

// File: bench/tb_rgba_over_blend_with_opacity.sv
// ----------------------------------------------------------------------------
// RGBA over blend testbench
// Drives pixel pairs through the blender under several opacity settings and
// handshake pressure phases, and checks every blended pixel against a local
// integer model of straight-alpha over compositing.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_rgba_over_blend_with_opacity;

  localparam int LATENCY    = 13;
  localparam int WDOG_LIMIT = 4000;
  localparam int NPHASE     = 8;

  typedef struct packed {
    logic [7:0] dr, dg, db, da, sr, sg, sb, sa;
  } pair_t;

  typedef struct packed {
    logic [7:0] r, g, b, a;
  } rgba_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic       layer_opacity_valid = 1'b0;
  logic       layer_opacity_ready;
  logic [7:0] layer_opacity = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] dst_red = 0, dst_green = 0, dst_blue = 0, dst_alpha = 0;
  logic [7:0] src_red = 0, src_green = 0, src_blue = 0, src_alpha = 0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_red, out_green, out_blue, out_alpha;

  rgba_over_blend_with_opacity u_dut (
    .clk(clk), .rst(rst),
    .layer_opacity_valid(layer_opacity_valid), .layer_opacity_ready(layer_opacity_ready),
    .layer_opacity(layer_opacity),
    .in_valid(in_valid), .in_ready(in_ready),
    .dst_red(dst_red), .dst_green(dst_green), .dst_blue(dst_blue), .dst_alpha(dst_alpha),
    .src_red(src_red), .src_green(src_green), .src_blue(src_blue), .src_alpha(src_alpha),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue), .out_alpha(out_alpha)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  pair_t pending_pairs[$];
  rgba_t blended_expect[$];
  logic [7:0] opacity_model = 8'd255;
  int  src_idle_pct = 0;
  int  dst_stall_pct = 0;
  int  errors = 0;
  int  idle_cycles = 0;
  bit  cfg_pending = 1'b0;
  logic [7:0] cfg_value = 8'd0;

  function automatic logic [7:0] mix_channel(int cs, int cd, int sa, int da, int n);
    longint num;
    longint q;
    num = longint'(cs) * sa * 255 + longint'(cd) * da * (255 - sa);
    q = (2 * num + n) / (2 * longint'(n));
    if (q > 255) q = 255;
    return q[7:0];
  endfunction

  function automatic rgba_t blend_over(pair_t p, logic [7:0] op);
    rgba_t o;
    int sa, da, n, al;
    sa = (int'(p.sa) * int'(op)) / 255;
    da = p.da;
    if (sa == 0) begin
      o = '{p.dr, p.dg, p.db, p.da};
    end else if (sa >= 255) begin
      o = '{p.sr, p.sg, p.sb, 8'd255};
    end else begin
      n = 255 * sa + da * (255 - sa);
      o.r = mix_channel(p.sr, p.dr, sa, da, n);
      o.g = mix_channel(p.sg, p.dg, sa, da, n);
      o.b = mix_channel(p.sb, p.db, sa, da, n);
      al = (2 * n + 255) / 510;
      if (al > 255) al = 255;
      o.a = al[7:0];
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  // driver: holds payload until the transfer
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      layer_opacity_valid <= 1'b0;
    end else begin
      if (layer_opacity_valid && layer_opacity_ready) begin
        opacity_model = layer_opacity;
        cfg_pending = 1'b0;
      end
      if (cfg_pending) begin
        layer_opacity_valid <= 1'b1;
        layer_opacity <= cfg_value;
      end else begin
        layer_opacity_valid <= 1'b0;
      end
      if (in_valid && in_ready) begin
        blended_expect.push_back(blend_over(pending_pairs.pop_front(), opacity_model));
      end
      if (!(in_valid && !in_ready)) begin
        if (pending_pairs.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          in_valid <= 1'b1;
          {dst_red, dst_green, dst_blue, dst_alpha,
           src_red, src_green, src_blue, src_alpha} <= pending_pairs[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= dst_stall_pct);
    end
  end

  // monitor: check each output transfer
  always @(posedge clk) begin
    rgba_t want;
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("watchdog expired at %0t", $time);
        $display("FAIL");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (blended_expect.size() == 0) begin
          $display("unexpected output at %0t", $time);
          errors++;
        end else begin
          want = blended_expect.pop_front();
          if (out_red !== want.r) report_mismatch("red", out_red, want.r);
          if (out_green !== want.g) report_mismatch("green", out_green, want.g);
          if (out_blue !== want.b) report_mismatch("blue", out_blue, want.b);
          if (out_alpha !== want.a) report_mismatch("alpha", out_alpha, want.a);
        end
      end
    end
  end

  function automatic pair_t random_pair();
    pair_t p;
    p = {$urandom, $urandom};
    case ($urandom_range(5))
      0: p.sa = 8'd0;
      1: p.sa = 8'd255;
      2: p.da = 8'd0;
      3: p.da = 8'd255;
      default: ;
    endcase
    return p;
  endfunction

  task automatic drain_and_set(logic [7:0] op);
    while (pending_pairs.size() > 0 || in_valid || blended_expect.size() > 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
    cfg_value = op;
    cfg_pending = 1'b1;
    while (cfg_pending) @(posedge clk);
    @(posedge clk);
  endtask

  initial begin
    logic [7:0] ops[NPHASE];
    int idle_tab[4][2];
    ops = '{8'd255, 8'd0, 8'd1, 8'd128, 8'd254, 8'd37, 8'd200, 8'd255};
    idle_tab = '{'{0, 0}, '{62, 0}, '{0, 62}, '{15, 15}};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: extremes, transparent, opaque and partial coverage
    pending_pairs.push_back('{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
    pending_pairs.push_back('{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff});
    pending_pairs.push_back('{8'hff, 8'h00, 8'hff, 8'h00, 8'h00, 8'hff, 8'h00, 8'hff});
    pending_pairs.push_back('{8'h12, 8'h34, 8'h56, 8'h78, 8'h9a, 8'hbc, 8'hde, 8'h00});
    pending_pairs.push_back('{8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01});
    pending_pairs.push_back('{8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 8'hfe});
    pending_pairs.push_back('{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h80});
    pending_pairs.push_back('{8'h00, 8'hff, 8'h00, 8'h00, 8'hff, 8'h00, 8'hff, 8'h7f});
    drain_and_set(8'd128);
    pending_pairs.push_back('{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff});
    pending_pairs.push_back('{8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'h01});
    pending_pairs.push_back('{8'h80, 8'h40, 8'h20, 8'hff, 8'h01, 8'h02, 8'h03, 8'hc0});
    for (int ph = 0; ph < NPHASE; ph++) begin
      drain_and_set(ops[ph]);
      src_idle_pct = idle_tab[ph % 4][0];
      dst_stall_pct = idle_tab[ph % 4][1];
      for (int i = 0; i < 235; i++) pending_pairs.push_back(random_pair());
    end
    while (pending_pairs.size() > 0 || in_valid || blended_expect.size() > 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
